@@ sv/kif_pkg.sv @@
package kif_pkg;

   // Request action codes.
   localparam logic ACTION_KEY   = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   // Extended key codes.
   localparam logic [7:0] EXT_ENTER      = 8'd0;
   localparam logic [7:0] EXT_BACKSPACE  = 8'd1;
   localparam logic [7:0] EXT_UP         = 8'd2;
   localparam logic [7:0] EXT_DOWN       = 8'd3;
   localparam logic [7:0] EXT_FKEY_FIRST = 8'd4;
   localparam logic [7:0] EXT_FKEY_LAST  = 8'd15;

   // Bytes queued for Enter and Backspace.
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;

   // Scroll command codes.
   localparam logic [1:0] SCROLL_NONE = 2'd0;
   localparam logic [1:0] SCROLL_DOWN = 2'd1;
   localparam logic [1:0] SCROLL_UP   = 2'd2;

   localparam int CHAR_W   = 8;
   localparam int SELECT_W = 4;
   localparam int FILL_W   = 7;

   // Decoded form of one request.
   typedef struct packed {
      logic                push;
      logic [CHAR_W-1:0]   push_byte;
      logic                pop;
      logic [1:0]          scroll_cmd;
      logic                select_valid;
      logic [SELECT_W-1:0] select_index;
   } kif_cmd_type;

   // Outcome of a request against the queue state.
   typedef struct packed {
      logic              popped;
      logic              dropped;
      logic [FILL_W-1:0] fill_level;
   } kif_stat_type;

endpackage

@@ sv/keyboard_input_fifo.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    action, key_extended, key_code,
//                                             shift_held, alt_held
// rsp_      out        rsp_valid/rsp_ready    char_valid, char_out, dropped,
//                                             scroll_cmd, select_valid,
//                                             select_index, fill_level
//
// One request is taken per clock cycle unless a stalled response holds it
// back; each yields one response via stage one and the output register, a
// popped byte read through the registered read port of the byte store.
// Synchronous active-high reset empties the queue (pointers and count to
// zero) and clears both pipeline stages; the byte store is not cleared.
// A stall holds both stages, and req_ready falls only once both are occupied.
module keyboard_input_fifo
   import kif_pkg::*;
#(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic                req_key_extended,
   input  logic [7:0]          req_key_code,
   input  logic                req_shift_held,
   input  logic                req_alt_held,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_char_valid,
   output logic [7:0]          rsp_char_out,
   output logic                rsp_dropped,
   output logic [1:0]          rsp_scroll_cmd,
   output logic                rsp_select_valid,
   output logic [3:0]          rsp_select_index,
   output logic [6:0]          rsp_fill_level
);

   localparam int PTR_W = $clog2(BUFFER_DEPTH);

   kif_cmd_type          cmd;
   kif_stat_type         stat;
   logic                 accept;
   logic                 ram_wr_en, ram_rd_en;
   logic [PTR_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [CHAR_W-1:0]    ram_wr_data, ram_rd_data;

   // Stage one holds everything but the popped byte, which sits in the
   // read register of the byte store until it moves to the output.
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_popped_ff;
   logic                 s1_dropped_ff;
   logic [1:0]           s1_scroll_ff;
   logic                 s1_select_valid_ff;
   logic [SELECT_W-1:0]  s1_select_index_ff;
   logic [FILL_W-1:0]    s1_fill_ff;
   logic                 s1_advance;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_char_valid_ff;
   logic [CHAR_W-1:0]    out_char_ff;
   logic                 out_dropped_ff;
   logic [1:0]           out_scroll_ff;
   logic                 out_select_valid_ff;
   logic [SELECT_W-1:0]  out_select_index_ff;
   logic [FILL_W-1:0]    out_fill_ff;

   // Stage one can move on when the output register is empty or draining.
   // A new request may enter stage one when it is empty or moving on; the
   // byte store read register therefore only changes once its byte is taken.
   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;

   kif_decode u_decode (
      .action       (req_action),
      .key_extended (req_key_extended),
      .key_code     (req_key_code),
      .shift_held   (req_shift_held),
      .alt_held     (req_alt_held),
      .cmd          (cmd)
   );

   kif_queue_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_queue_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (cmd),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .stat        (stat)
   );

   // A pop never reads the entry written in the same cycle, since a request
   // either pushes or pops, never both.
   kif_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_byte_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_popped_ff       <= stat.popped;
         s1_dropped_ff      <= stat.dropped;
         s1_scroll_ff       <= cmd.scroll_cmd;
         s1_select_valid_ff <= cmd.select_valid;
         s1_select_index_ff <= cmd.select_index;
         s1_fill_ff         <= stat.fill_level;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_char_valid_ff   <= s1_popped_ff;
         out_char_ff         <= s1_popped_ff ? ram_rd_data : '0;
         out_dropped_ff      <= s1_dropped_ff;
         out_scroll_ff       <= s1_scroll_ff;
         out_select_valid_ff <= s1_select_valid_ff;
         out_select_index_ff <= s1_select_index_ff;
         out_fill_ff         <= s1_fill_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_char_valid   = out_char_valid_ff;
   assign rsp_char_out     = out_char_ff;
   assign rsp_dropped      = out_dropped_ff;
   assign rsp_scroll_cmd   = out_scroll_ff;
   assign rsp_select_valid = out_select_valid_ff;
   assign rsp_select_index = out_select_index_ff;
   assign rsp_fill_level   = out_fill_ff;

endmodule

@@ sv/kif_ram.sv @@
module kif_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/kif_decode.sv @@
module kif_decode
   import kif_pkg::*;
(
   input  logic              action,
   input  logic              key_extended,
   input  logic [CHAR_W-1:0] key_code,
   input  logic              shift_held,
   input  logic              alt_held,
   output kif_cmd_type       cmd
);

   always_comb begin
      cmd = '0;
      case (action)
         ACTION_DRAIN: begin
            cmd.pop = 1'b1;
         end
         ACTION_KEY: begin
            if (!key_extended) begin
               cmd.push      = 1'b1;
               cmd.push_byte = key_code;
            end else begin
               case (key_code)
                  EXT_ENTER: begin
                     cmd.push      = 1'b1;
                     cmd.push_byte = CHAR_NEWLINE;
                  end
                  EXT_BACKSPACE: begin
                     cmd.push      = 1'b1;
                     cmd.push_byte = CHAR_BACKSPACE;
                  end
                  EXT_UP: begin
                     cmd.scroll_cmd = shift_held ? SCROLL_DOWN : SCROLL_NONE;
                  end
                  EXT_DOWN: begin
                     cmd.scroll_cmd = shift_held ? SCROLL_UP : SCROLL_NONE;
                  end
                  default: begin
                     // Function keys only matter with alt held.
                     if (alt_held && key_code >= EXT_FKEY_FIRST
                         && key_code <= EXT_FKEY_LAST) begin
                        cmd.select_valid = 1'b1;
                        cmd.select_index = key_code[SELECT_W-1:0]
                                         - EXT_FKEY_FIRST[SELECT_W-1:0];
                     end
                  end
               endcase
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/kif_queue_ctrl.sv @@
module kif_queue_ctrl
   import kif_pkg::*;
#(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  kif_cmd_type                     cmd,
   output logic                            ram_wr_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0] ram_wr_addr,
   output logic [CHAR_W-1:0]               ram_wr_data,
   output logic                            ram_rd_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0] ram_rd_addr,
   output kif_stat_type                    stat
);

   localparam int PTR_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int EXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_after;
   logic [EXT_W-1:0] count_ext;
   logic             full, empty, push_ok, pop_ok;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign push_ok = cmd.push && !full;
   assign pop_ok  = cmd.pop && !empty;

   always_comb begin
      count_after = count_ff;
      if (push_ok) begin
         count_after = count_ff + CNT_W'(1);
      end else if (pop_ok) begin
         count_after = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         count_in = count_after;
         if (push_ok) begin
            wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign ram_wr_en   = accept && push_ok;
   assign ram_wr_addr = wr_ptr_ff;
   assign ram_wr_data = cmd.push_byte;
   assign ram_rd_en   = accept && pop_ok;
   assign ram_rd_addr = rd_ptr_ff;

   // The fill level reports only the low bits of the count.
   assign count_ext       = EXT_W'(count_after);
   assign stat.popped     = pop_ok;
   assign stat.dropped    = cmd.push && full;
   assign stat.fill_level = count_ext[FILL_W-1:0];

endmodule
